[sv/s2d_pkg.sv]
// ----------------------------------------------------------------------------
// s2d_pkg: shared types and constants
// Widths, character codes and stage words for the signed binary to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package s2d_pkg;

  localparam int BIN_W             = 64;
  localparam int SIZE_W            = 8;
  localparam int DIGIT_W           = 4;
  localparam int NUM_DIGITS        = 19;
  localparam int BCD_W             = NUM_DIGITS * DIGIT_W;
  localparam int COUNT_W           = 5;
  localparam int CHAR_W            = 8;
  localparam int STEPS_PER_STAGE   = 4;
  localparam int NUM_DABBLE_STAGES = BIN_W / STEPS_PER_STAGE;

  localparam logic [CHAR_W-1:0]  CH_ZERO       = 8'h30;
  localparam logic [CHAR_W-1:0]  CH_MINUS      = 8'h2D;
  localparam logic [CHAR_W-1:0]  CH_NONE       = 8'h00;
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT  = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADJUST = 4'd3;
  localparam logic [SIZE_W:0]    ROOM_RESERVED = 9'd2;

  // Word moving through the shift-add-3 stages
  typedef struct packed {
    logic [BCD_W-1:0]  bcd;
    logic [BIN_W-1:0]  bin;
    logic              neg;
    logic [SIZE_W-1:0] size;
  } dabble_t;

  // Word handed to the serializer
  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic               neg;
    logic               ok;
    logic [COUNT_W-1:0] nd;
  } conv_t;

endpackage

`default_nettype wire

[sv/s2d_dabble_stage.sv]
// ----------------------------------------------------------------------------
// s2d_dabble_stage: one register stage of the binary to BCD converter
// Runs a fixed number of shift-add-3 steps on the word and registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module s2d_dabble_stage
  import s2d_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dabble_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output dabble_t      out_data
);

  dabble_t work;

  // Shift-add-3 steps: digits adjust independently, then the word shifts left
  always_comb begin
    work = in_data;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (work.bcd[d*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
          work.bcd[d*DIGIT_W +: DIGIT_W] = work.bcd[d*DIGIT_W +: DIGIT_W] + DABBLE_ADJUST;
        end
      end
      {work.bcd, work.bin} = {work.bcd[BCD_W-2:0], work.bin, 1'b0};
    end
  end

  assign in_ready = !out_valid || out_ready;

  // Stage register; holds while the next stage stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= work;
    end
  end

endmodule

`default_nettype wire

[sv/s2d_count_stage.sv]
// ----------------------------------------------------------------------------
// s2d_count_stage: digit count and fit check
// Finds the number of significant decimal digits and compares it with the
// room the buffer leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module s2d_count_stage
  import s2d_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dabble_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output conv_t        out_data
);

  logic [COUNT_W-1:0] nd;
  logic               fits;

  // Highest nonzero digit sets the count; zero still has one digit
  always_comb begin
    nd = COUNT_W'(1);
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (in_data.bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
        nd = COUNT_W'(d + 1);
      end
    end
  end

  // Room check without wrap: count plus sign and terminator within size
  assign fits = ({1'b0, in_data.size} >= ({{(SIZE_W + 1 - COUNT_W){1'b0}}, nd}
                                          + ROOM_RESERVED));

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.bcd <= in_data.bcd;
      out_data.neg <= in_data.neg;
      out_data.ok  <= fits;
      out_data.nd  <= nd;
    end
  end

endmodule

`default_nettype wire

[sv/s2d_serializer.sv]
// ----------------------------------------------------------------------------
// s2d_serializer: character serializer
// Holds one converted word and sends its sign and digits, most significant
// first, one character per word on the output, or a single failure word.
// ----------------------------------------------------------------------------
`default_nettype none

module s2d_serializer
  import s2d_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire conv_t         in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               ok,
  output logic [CHAR_W-1:0]  out_char,
  output logic               last,
  output logic [COUNT_W-1:0] digit_count
);

  logic                busy;
  logic                sign_pend;
  logic [COUNT_W-1:0]  idx;
  conv_t               hold;
  logic [DIGIT_W-1:0]  digits [NUM_DIGITS];
  logic                advance;

  logic                emit_ok;
  logic [CHAR_W-1:0]   emit_char;
  logic                emit_last;
  logic [COUNT_W-1:0]  emit_count;

  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      digits[d] = hold.bcd[d*DIGIT_W +: DIGIT_W];
    end
  end

  assign advance  = !out_valid || out_ready;
  assign in_ready = !busy;

  // Next character of the held word
  always_comb begin
    priority if (!hold.ok) begin
      emit_ok    = 1'b0;
      emit_char  = CH_NONE;
      emit_last  = 1'b1;
      emit_count = '0;
    end else if (sign_pend) begin
      emit_ok    = 1'b1;
      emit_char  = CH_MINUS;
      emit_last  = 1'b0;
      emit_count = hold.nd;
    end else begin
      emit_ok    = 1'b1;
      emit_char  = CH_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, digits[idx]};
      emit_last  = (idx == '0);
      emit_count = hold.nd;
    end
  end

  // Control: load when idle, step through characters as the output frees
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= busy;
      end
      if (!busy) begin
        busy <= in_valid;
      end else if (advance && emit_last) begin
        busy <= 1'b0;
      end
    end
  end

  // Held word, position and output register
  always_ff @(posedge clk) begin
    if (!busy && in_valid) begin
      hold      <= in_data;
      sign_pend <= in_data.neg;
      idx       <= in_data.nd - COUNT_W'(1);
    end else if (busy && advance) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else begin
        idx <= idx - COUNT_W'(1);
      end
    end
    if (busy && advance) begin
      ok          <= emit_ok;
      out_char    <= emit_char;
      last        <= emit_last;
      digit_count <= emit_count;
    end
  end

endmodule

`default_nettype wire

[sv/signed_binary_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii: 64-bit signed integer to decimal text
// Magnitude stage, sixteen shift-add-3 stages, a count stage and a
// character serializer with an output register.
// ----------------------------------------------------------------------------
// Path: magnitude register, sixteen dabble stage registers, count register, then
//   the serializer's held word and its output register.
// Pace: the serializer takes a new word only once the held one's last character
//   is out; the stages ahead take a word every cycle unless stalled downstream.
// Reset: synchronous, clears all valid bits and the serializer; no clearing pass.
`default_nettype none

module signed_binary_to_decimal_ascii
  import s2d_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [BIN_W-1:0]    value,
  input  wire logic [SIZE_W-1:0]   buffer_size,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     ok,
  output logic [CHAR_W-1:0]        out_char,
  output logic                     last,
  output logic [COUNT_W-1:0]       digit_count
);

  logic    front_valid;
  dabble_t front_data;
  logic    front_ready;

  logic    stg_valid [NUM_DABBLE_STAGES+1];
  logic    stg_ready [NUM_DABBLE_STAGES+1];
  dabble_t stg_data  [NUM_DABBLE_STAGES+1];

  logic    cnt_valid;
  logic    cnt_ready;
  conv_t   cnt_data;

  // Magnitude stage: two's complement negate; most negative maps to 2^63
  assign in_ready = !front_valid || front_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (in_ready) begin
      front_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      front_data.bcd  <= '0;
      front_data.bin  <= value[BIN_W-1] ? (~value + BIN_W'(1)) : value;
      front_data.neg  <= value[BIN_W-1];
      front_data.size <= buffer_size;
    end
  end

  assign stg_valid[0] = front_valid;
  assign stg_data[0]  = front_data;
  assign front_ready  = stg_ready[0];

  // Binary to BCD chain
  for (genvar g = 0; g < NUM_DABBLE_STAGES; g++) begin : g_dabble
    s2d_dabble_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_data   (stg_data[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_data  (stg_data[g+1])
    );
  end

  s2d_count_stage u_count (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stg_valid[NUM_DABBLE_STAGES]),
    .in_ready  (stg_ready[NUM_DABBLE_STAGES]),
    .in_data   (stg_data[NUM_DABBLE_STAGES]),
    .out_valid (cnt_valid),
    .out_ready (cnt_ready),
    .out_data  (cnt_data)
  );

  s2d_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (cnt_valid),
    .in_ready    (cnt_ready),
    .in_data     (cnt_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .out_char    (out_char),
    .last        (last),
    .digit_count (digit_count)
  );

  // Failure word is always a lone, empty, final word
  a_fail_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> last && out_char == CH_NONE && digit_count == '0)
    else $error("failure word malformed");

  // Successful words carry a real digit count
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && ok |-> digit_count != '0 && digit_count <= COUNT_W'(NUM_DIGITS))
    else $error("digit count out of range");

  // Successful characters are a sign or a decimal digit; a sign is never last
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && ok |-> (out_char == CH_MINUS && !last) ||
                        (out_char >= CH_ZERO && out_char <= CH_ZERO + 8'd9))
    else $error("bad character");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: signed binary to decimal ASCII converter
// Sends 64-bit values with buffer sizes and checks every output word (sign,
// digits, last mark, digit count, fit flag) against a local predictor. The
// sender runs in bursts, the receiver stalls on its own pattern and twice
// holds off long enough to back the pipeline up into the input.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import s2d_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEC_BASE   = 10;
  localparam int RAND_WORDS = 220;
  localparam int HOLD_LEN   = 300;

  typedef struct {
    logic [BIN_W-1:0]  value;
    logic [SIZE_W-1:0] size;
  } conv_req_t;

  typedef struct packed {
    logic               ok;
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic [COUNT_W-1:0] count;
  } text_char_t;

  logic                clk;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [BIN_W-1:0]    value       = '0;
  logic [SIZE_W-1:0]   buffer_size = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic                ok;
  logic [CHAR_W-1:0]   out_char;
  logic                last;
  logic [COUNT_W-1:0]  digit_count;

  conv_req_t  req_q[$];
  text_char_t text_q[$];
  int         err_cnt    = 0;
  int         taken      = 0;
  int         burst_left = 0;
  int         gap_left   = 0;
  int         hold_left  = 0;
  int         next_hold  = 60;
  int         mode_left  = 0;
  int         rx_mode    = 0;

  signed_binary_to_decimal_ascii u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .buffer_size (buffer_size),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .out_char    (out_char),
    .last        (last),
    .digit_count (digit_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report(input string msg);
    if (err_cnt < 40) $display("tb: mismatch: %s", msg);
    err_cnt++;
  endtask

  // two's complement magnitude; the most negative value gives 2^63 unsigned
  function automatic logic [BIN_W-1:0] magnitude(input logic [BIN_W-1:0] v);
    return v[BIN_W-1] ? (~v + 64'd1) : v;
  endfunction

  // expected characters of one conversion, most significant digit first
  task automatic predict_text(input logic [BIN_W-1:0] v, input logic [SIZE_W-1:0] sz);
    logic [BIN_W-1:0]   mag;
    logic [DIGIT_W-1:0] dig [NUM_DIGITS];
    int                 nd;
    text_char_t         c;
    mag = magnitude(v);
    nd = 0;
    do begin
      dig[nd] = DIGIT_W'(mag % DEC_BASE);
      nd++;
      mag = mag / DEC_BASE;
    end while (mag != 0);
    if (int'(sz) < int'(ROOM_RESERVED) || nd > int'(sz) - int'(ROOM_RESERVED)) begin
      c = '{ok: 1'b0, ch: CH_NONE, last: 1'b1, count: '0};
      text_q.push_back(c);
      return;
    end
    if (v[BIN_W-1]) begin
      c = '{ok: 1'b1, ch: CH_MINUS, last: 1'b0, count: COUNT_W'(nd)};
      text_q.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c = '{ok: 1'b1, ch: CH_ZERO + CHAR_W'(dig[i]), last: (i == 0),
            count: COUNT_W'(nd)};
      text_q.push_back(c);
    end
  endtask

  task automatic push_req(input logic [BIN_W-1:0] v, input logic [SIZE_W-1:0] sz);
    conv_req_t r;
    r.value = v;
    r.size  = sz;
    req_q.push_back(r);
  endtask

  // random word: mostly values of random length with sizes near the fit edge
  task automatic push_random();
    logic [BIN_W-1:0] v;
    logic [BIN_W-1:0] mag;
    logic [BIN_W-1:0] p;
    int               nd;
    int               sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      v = {$urandom(), $urandom()} >> $urandom_range(0, 63);
      if ($urandom_range(0, 1)) v = ~v + 64'd1;
    end else if (sel == 6) begin
      p = 64'd1;
      repeat ($urandom_range(0, 18)) p = p * DEC_BASE;
      v = p + 64'd1 - 64'($urandom_range(0, 2));
      if ($urandom_range(0, 1)) v = ~v + 64'd1;
    end else if (sel == 7) begin
      v = {$urandom(), $urandom()};
    end else begin
      case ($urandom_range(0, 3))
        0:       v = 64'h8000_0000_0000_0000;
        1:       v = 64'h7FFF_FFFF_FFFF_FFFF;
        2:       v = 64'd0;
        default: v = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
    end
    mag = magnitude(v);
    nd = 0;
    do begin
      nd++;
      mag = mag / DEC_BASE;
    end while (mag != 0);
    sel = $urandom_range(0, 9);
    if (sel <= 6)      push_req(v, SIZE_W'(nd + 2 + $urandom_range(0, 3)));
    else if (sel == 7) push_req(v, SIZE_W'(nd + 1 + $urandom_range(0, 1)));
    else if (sel == 8) push_req(v, SIZE_W'($urandom_range(0, 255)));
    else               push_req(v, SIZE_W'($urandom_range(0, 3)));
  endtask

  // sender: bursts of words with random gaps, predicts on acceptance
  always @(posedge clk) begin
    conv_req_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_text(value, buffer_size);
        taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || req_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          r = req_q.pop_front();
          in_valid    <= 1'b1;
          value       <= r.value;
          buffer_size <= r.size;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // receiver: stall pattern changes in stretches, plus two long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (taken >= next_hold) begin
      hold_left = HOLD_LEN;
      next_hold += 100;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  // monitor: each output word against the oldest expected character
  always @(posedge clk) begin
    text_char_t got;
    text_char_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{ok: ok, ch: out_char, last: last, count: digit_count};
      if (text_q.size() == 0) begin
        report($sformatf("unexpected word ok=%0d ch=%h last=%0d cnt=%0d",
                         got.ok, got.ch, got.last, got.count));
      end else begin
        want = text_q.pop_front();
        if (got.ok !== want.ok)
          report($sformatf("ok got %0d want %0d", got.ok, want.ok));
        if (got.ch !== want.ch)
          report($sformatf("out_char got %h want %h", got.ch, want.ch));
        if (got.last !== want.last)
          report($sformatf("last got %0d want %0d", got.last, want.last));
        if (got.count !== want.count)
          report($sformatf("digit_count got %0d want %0d", got.count, want.count));
      end
    end
  end

  initial begin
    // zero against every small size, then small values against small and large sizes
    push_req(64'd0, 8'd0);
    push_req(64'd0, 8'd1);
    push_req(64'd0, 8'd2);
    push_req(64'd0, 8'd3);
    push_req(64'hFFFF_FFFF_FFFF_FFFF, 8'd3);
    push_req(64'd5, 8'd255);
    push_req(64'd1, 8'd1);
    push_req(-64'sd7, 8'd2);
    // most negative and most positive, on both sides of the fit edge
    push_req(64'h8000_0000_0000_0000, 8'd20);
    push_req(64'h8000_0000_0000_0000, 8'd21);
    push_req(64'h8000_0000_0000_0000, 8'd255);
    push_req(64'h7FFF_FFFF_FFFF_FFFF, 8'd20);
    push_req(64'h7FFF_FFFF_FFFF_FFFF, 8'd21);
    // digit count steps at powers of ten
    push_req(64'd9, 8'd3);
    push_req(64'd10, 8'd3);
    push_req(64'd10, 8'd4);
    push_req(-64'sd10, 8'd4);
    push_req(64'd999_999_999_999_999_999, 8'd20);
    push_req(64'd1_000_000_000_000_000_000, 8'd20);
    push_req(64'd1_000_000_000_000_000_000, 8'd21);
    push_req(-64'sd1_000_000_000_000_000_000, 8'd21);
    push_req(64'd123_456_789, 8'd11);
    repeat (RAND_WORDS) push_random();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || in_valid) @(posedge clk);
    while (text_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0 && text_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
sv/s2d_pkg.sv
sv/s2d_dabble_stage.sv
sv/s2d_count_stage.sv
sv/s2d_serializer.sv
sv/signed_binary_to_decimal_ascii.sv
tb/sv/testbench.sv
